[hw/rtl/opc_pkg.sv]
// Shared constants, types and tables for the orbit position calculator.
// Depends on nothing; every other file of the block uses it.
package opc_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ANGLE_BITS   = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int CORDIC_USED  = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

   localparam int DAY_W  = 32;
   localparam int BASE_W = 16;
   localparam int PER_W  = 16;
   localparam int RAD_W  = 10;
   localparam int GAIN_W = 16;
   localparam int CEN_W  = 12;
   localparam int POS_W  = 13;
   localparam int ANG_W  = 16;
   localparam int FRAC_W = 8;
   localparam int MAG_W  = DAY_W + GAIN_W;
   localparam int QUO1_W = MAG_W - FRAC_W;
   localparam int REM_W  = PER_W + FRAC_W;
   localparam int VEC_W  = 18;
   localparam int Z_W    = 34;
   localparam int PROD_W = VEC_W + RAD_W + 1;
   localparam int SUM_W  = 31;
   localparam int Q14    = 14;

   localparam logic signed [VEC_W-1:0] CORDIC_K_Q14 = VEC_W'(9949);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_CENTER_X   = 2'd0;
   localparam logic [1:0] REG_CENTER_Y   = 2'd1;
   localparam logic [1:0] REG_SPEED_GAIN = 2'd2;
   localparam logic [GAIN_W-1:0] SPEED_GAIN_RESET = GAIN_W'(256);

   localparam logic [31:0] ATAN_TURNS_Q32 [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

   // Fields that ride along with the phase divider pipeline.
   typedef struct packed {
      logic              neg;
      logic [FRAC_W-1:0] low;
      logic [PER_W-1:0]  period;
      logic [BASE_W-1:0] base;
      logic [RAD_W-1:0]  radius;
      logic              last;
   } side_type;

   typedef struct packed {
      logic             valid;
      logic [ANG_W-1:0] ang16;
      logic [RAD_W-1:0] radius;
      logic             last;
   } tag_type;

endpackage

[hw/rtl/opc_if.sv]
// Valid/ready channel interfaces for bodies in and positions out.
// Depends on opc_pkg for the field widths.
interface opc_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [opc_pkg::DAY_W-1:0]  day;
   logic [opc_pkg::BASE_W-1:0]        base_angle_turns;
   logic [opc_pkg::PER_W-1:0]         period_days;
   logic [opc_pkg::RAD_W-1:0]         orbit_radius;
   logic                              last_in;
   modport source (output valid, day, base_angle_turns, period_days, orbit_radius, last_in,
                   input ready);
   modport sink (input valid, day, base_angle_turns, period_days, orbit_radius, last_in,
                 output ready);
endinterface

interface opc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [opc_pkg::POS_W-1:0]  pos_x;
   logic signed [opc_pkg::POS_W-1:0]  pos_y;
   logic [opc_pkg::ANG_W-1:0]         angle_turns;
   logic                              last_out;
   modport source (output valid, pos_x, pos_y, angle_turns, last_out, input ready);
   modport sink (input valid, pos_x, pos_y, angle_turns, last_out, output ready);
endinterface

[hw/rtl/orbit_position_calculator.sv]
// Top level of the orbit position calculator: register port and the three
// pipeline sections. Depends on opc_pkg, opc_if, opc_phase, opc_cordic, opc_position.
//
//   channel   direction  transfer on              payload
//   req_ch    in         valid && ready           day, base angle, period, radius, last
//   rsp_ch    out        valid && ready           pos_x, pos_y, angle_turns, last_out
//   csr_*     in/out     psel & penable & pwrite  center_x, center_y, speed_gain
//
// One transaction enters per cycle unless a result is held back at the output. The stages:
// 1 multiply, 40 remainder steps, 1 fix-up, 16 fraction steps, 1 angle add,
// 18 CORDIC stages, 2 position stages. The remainder divider sets the depth.
// Reset is synchronous: it clears the stage valid bits and both centers and sets the speed gain to 256.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
module orbit_position_calculator (
   input  logic                               clock,
   input  logic                               reset,
   opc_req_if.sink                            req_ch,
   opc_rsp_if.source                          rsp_ch,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [opc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [opc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [opc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import opc_pkg::*;

   logic [CEN_W-1:0]  center_x_ff, center_y_ff;
   logic [GAIN_W-1:0] speed_gain_ff;
   logic              csr_write;
   logic [1:0]        csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         speed_gain_ff <= SPEED_GAIN_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_CENTER_X:   center_x_ff   <= csr_pwdata[CEN_W-1:0];
            REG_CENTER_Y:   center_y_ff   <= csr_pwdata[CEN_W-1:0];
            REG_SPEED_GAIN: speed_gain_ff <= csr_pwdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_CENTER_X:   csr_prdata = CSR_DATA_W'(center_x_ff);
         REG_CENTER_Y:   csr_prdata = CSR_DATA_W'(center_y_ff);
         REG_SPEED_GAIN: csr_prdata = CSR_DATA_W'(speed_gain_ff);
         default:        csr_prdata = '0;
      endcase
   end

   logic en;
   assign en           = !(rsp_ch.valid && !rsp_ch.ready);
   assign req_ch.ready = en;

   logic                  ph_valid;
   logic [ANGLE_BITS-1:0] ph_angle;
   logic [RAD_W-1:0]      ph_radius;
   logic                  ph_last;

   opc_phase u_phase (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .speed_gain (speed_gain_ff),
      .in_valid   (req_ch.valid),
      .day        (req_ch.day),
      .base       (req_ch.base_angle_turns),
      .period     (req_ch.period_days),
      .radius     (req_ch.orbit_radius),
      .last_in    (req_ch.last_in),
      .out_valid  (ph_valid),
      .angle      (ph_angle),
      .out_radius (ph_radius),
      .out_last   (ph_last)
   );

   tag_type                 co_tag;
   logic signed [VEC_W-1:0] co_cos, co_sin;

   opc_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (ph_valid),
      .angle    (ph_angle),
      .radius   (ph_radius),
      .last_in  (ph_last),
      .out_tag  (co_tag),
      .cos_q14  (co_cos),
      .sin_q14  (co_sin)
   );

   opc_position u_position (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .center_x    (center_x_ff),
      .center_y    (center_y_ff),
      .in_tag      (co_tag),
      .cos_q14     (co_cos),
      .sin_q14     (co_sin),
      .out_valid   (rsp_ch.valid),
      .pos_x       (rsp_ch.pos_x),
      .pos_y       (rsp_ch.pos_y),
      .angle_turns (rsp_ch.angle_turns),
      .last_out    (rsp_ch.last_out)
   );
endmodule

[hw/rtl/opc_phase.sv]
// Angle pipeline: day times gain, floor remainder by the period, fraction
// by a second bit-per-stage divider, plus the base angle. Uses opc_pkg.
module opc_phase (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic [opc_pkg::GAIN_W-1:0]     speed_gain,
   input  logic                           in_valid,
   input  logic signed [opc_pkg::DAY_W-1:0] day,
   input  logic [opc_pkg::BASE_W-1:0]     base,
   input  logic [opc_pkg::PER_W-1:0]      period,
   input  logic [opc_pkg::RAD_W-1:0]      radius,
   input  logic                           last_in,
   output logic                           out_valid,
   output logic [opc_pkg::ANGLE_BITS-1:0] angle,
   output logic [opc_pkg::RAD_W-1:0]      out_radius,
   output logic                           out_last
);
   import opc_pkg::*;

   localparam int AB = ANGLE_BITS;

   logic [DAY_W-1:0] day_mag;
   logic             mul_v_ff;
   logic [MAG_W-1:0] mul_mag_ff;
   side_type         mul_s_ff;

   assign day_mag = day[DAY_W-1] ? DAY_W'(-day) : DAY_W'(day);

   always_ff @(posedge clock) begin
      if (reset) mul_v_ff <= 1'b0;
      else if (en) mul_v_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mul_mag_ff <= MAG_W'(day_mag * speed_gain);
         mul_s_ff   <= '{neg: day[DAY_W-1], low: '0, period: period, base: base,
                         radius: radius, last: last_in};
      end
   end

   // First divider: (mag >> 8) mod period, one quotient bit per stage.
   logic              d1_v_ff [QUO1_W];
   logic [PER_W-1:0]  d1_r_ff [QUO1_W];
   logic [QUO1_W-1:0] d1_n_ff [QUO1_W];
   side_type          d1_s_ff [QUO1_W];

   for (genvar k = 0; k < QUO1_W; k++) begin : g_d1
      logic              v_prev;
      logic [PER_W-1:0]  r_prev;
      logic [QUO1_W-1:0] n_prev;
      side_type          s_prev;
      logic [PER_W:0]    t;
      logic [PER_W-1:0]  r_in;
      if (k == 0) begin : g_first
         side_type s0;
         always_comb begin
            s0     = mul_s_ff;
            s0.low = mul_mag_ff[FRAC_W-1:0];
         end
         assign v_prev = mul_v_ff;
         assign r_prev = '0;
         assign n_prev = mul_mag_ff[MAG_W-1:FRAC_W];
         assign s_prev = s0;
      end else begin : g_next
         assign v_prev = d1_v_ff[k-1];
         assign r_prev = d1_r_ff[k-1];
         assign n_prev = d1_n_ff[k-1];
         assign s_prev = d1_s_ff[k-1];
      end
      assign t    = {r_prev, n_prev[QUO1_W-1-k]};
      assign r_in = (t >= {1'b0, s_prev.period}) ? PER_W'(t - {1'b0, s_prev.period})
                                                 : t[PER_W-1:0];
      always_ff @(posedge clock) begin
         if (reset) d1_v_ff[k] <= 1'b0;
         else if (en) d1_v_ff[k] <= v_prev;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            d1_r_ff[k] <= r_in;
            d1_n_ff[k] <= n_prev;
            d1_s_ff[k] <= s_prev;
         end
      end
   end

   // Floor remainder: a negative day reflects a nonzero remainder.
   logic             fx_v_ff;
   logic [REM_W-1:0] fx_rem_ff;
   side_type         fx_s_ff;
   logic [REM_W-1:0] rem_raw;
   logic [REM_W-1:0] rem_in;

   assign rem_raw = {d1_r_ff[QUO1_W-1], d1_s_ff[QUO1_W-1].low};
   assign rem_in  = (d1_s_ff[QUO1_W-1].neg && (rem_raw != '0))
                  ? REM_W'({d1_s_ff[QUO1_W-1].period, FRAC_W'(0)} - rem_raw) : rem_raw;

   always_ff @(posedge clock) begin
      if (reset) fx_v_ff <= 1'b0;
      else if (en) fx_v_ff <= d1_v_ff[QUO1_W-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fx_rem_ff <= rem_in;
         fx_s_ff   <= d1_s_ff[QUO1_W-1];
      end
   end

   // Second divider: (rem << (AB-8)) / period gives AB quotient bits.
   logic             d2_v_ff [AB];
   logic [PER_W-1:0] d2_r_ff [AB];
   logic [AB-1:0]    d2_n_ff [AB];
   logic [AB-1:0]    d2_q_ff [AB];
   side_type         d2_s_ff [AB];

   for (genvar j = 0; j < AB; j++) begin : g_d2
      logic             v_prev;
      logic [PER_W-1:0] r_prev;
      logic [AB-1:0]    n_prev;
      logic [AB-1:0]    q_prev;
      side_type         s_prev;
      logic [PER_W:0]   t;
      logic             ge;
      if (j == 0) begin : g_first
         logic [AB+FRAC_W-1:0] wide;
         assign wide   = {fx_rem_ff[FRAC_W-1:0], AB'(0)};
         assign v_prev = fx_v_ff;
         assign r_prev = fx_rem_ff[REM_W-1:FRAC_W];
         assign n_prev = wide[AB+FRAC_W-1:FRAC_W];
         assign q_prev = '0;
         assign s_prev = fx_s_ff;
      end else begin : g_next
         assign v_prev = d2_v_ff[j-1];
         assign r_prev = d2_r_ff[j-1];
         assign n_prev = d2_n_ff[j-1];
         assign q_prev = d2_q_ff[j-1];
         assign s_prev = d2_s_ff[j-1];
      end
      assign t  = {r_prev, n_prev[AB-1-j]};
      assign ge = (t >= {1'b0, s_prev.period});
      always_ff @(posedge clock) begin
         if (reset) d2_v_ff[j] <= 1'b0;
         else if (en) d2_v_ff[j] <= v_prev;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            d2_r_ff[j] <= ge ? PER_W'(t - {1'b0, s_prev.period}) : t[PER_W-1:0];
            d2_n_ff[j] <= n_prev;
            d2_q_ff[j] <= {q_prev[AB-2:0], ge};
            d2_s_ff[j] <= s_prev;
         end
      end
   end

   logic                  an_v_ff;
   logic [AB-1:0]         an_angle_ff;
   logic [RAD_W-1:0]      an_radius_ff;
   logic                  an_last_ff;
   logic [AB+BASE_W-1:0]  base_wide;
   logic [AB-1:0]         inc;
   side_type              s_end;

   assign s_end     = d2_s_ff[AB-1];
   assign base_wide = {s_end.base, AB'(0)} >> BASE_W;
   // A zero period leaves the body at its base angle.
   assign inc       = (s_end.period == '0) ? '0 : d2_q_ff[AB-1];

   always_ff @(posedge clock) begin
      if (reset) an_v_ff <= 1'b0;
      else if (en) an_v_ff <= d2_v_ff[AB-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         an_angle_ff  <= AB'(base_wide[AB-1:0] + inc);
         an_radius_ff <= s_end.radius;
         an_last_ff   <= s_end.last;
      end
   end

   assign out_valid  = an_v_ff;
   assign angle      = an_angle_ff;
   assign out_radius = an_radius_ff;
   assign out_last   = an_last_ff;
endmodule

[hw/rtl/opc_cordic.sv]
// Rotation-mode CORDIC, one micro-rotation per register stage, with the
// half-turn fold before and the sign restore after. Uses opc_pkg.
module opc_cordic (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [opc_pkg::ANGLE_BITS-1:0]   angle,
   input  logic [opc_pkg::RAD_W-1:0]        radius,
   input  logic                             last_in,
   output opc_pkg::tag_type                 out_tag,
   output logic signed [opc_pkg::VEC_W-1:0] cos_q14,
   output logic signed [opc_pkg::VEC_W-1:0] sin_q14
);
   import opc_pkg::*;

   localparam int AB = ANGLE_BITS;
   localparam int N  = CORDIC_USED;

   logic [AB+31:0]     a32_wide;
   logic [AB+ANG_W-1:0] a16_wide;
   logic [31:0]        a32;
   logic signed [Z_W-1:0] z_in;
   logic               flip_in;

   assign a32_wide = {angle, 32'd0} >> AB;
   assign a16_wide = {angle, ANG_W'(0)} >> AB;
   assign a32      = a32_wide[31:0];

   always_comb begin
      unique case (a32[31:30])
         2'b01, 2'b10: begin
            z_in    = Z_W'($signed({2'b00, a32}) - $signed(Z_W'(64'h80000000)));
            flip_in = 1'b1;
         end
         2'b11: begin
            z_in    = Z_W'($signed({2'b00, a32}) - $signed(Z_W'(64'h100000000)));
            flip_in = 1'b0;
         end
         default: begin
            z_in    = $signed({2'b00, a32});
            flip_in = 1'b0;
         end
      endcase
   end

   tag_type               pr_tag_ff;
   logic                  pr_flip_ff;
   logic signed [Z_W-1:0] pr_z_ff;

   always_ff @(posedge clock) begin
      if (reset) pr_tag_ff.valid <= 1'b0;
      else if (en) pr_tag_ff.valid <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pr_tag_ff.ang16  <= a16_wide[ANG_W-1:0];
         pr_tag_ff.radius <= radius;
         pr_tag_ff.last   <= last_in;
         pr_flip_ff       <= flip_in;
         pr_z_ff          <= z_in;
      end
   end

   tag_type               st_tag_ff  [N];
   logic                  st_flip_ff [N];
   logic signed [VEC_W-1:0] st_x_ff  [N];
   logic signed [VEC_W-1:0] st_y_ff  [N];
   logic signed [Z_W-1:0]   st_z_ff  [N];

   for (genvar i = 0; i < N; i++) begin : g_rot
      tag_type               tag_prev;
      logic                  flip_prev;
      logic signed [VEC_W-1:0] x_prev, y_prev, dx, dy;
      logic signed [Z_W-1:0]   z_prev, step;
      if (i == 0) begin : g_first
         assign tag_prev  = pr_tag_ff;
         assign flip_prev = pr_flip_ff;
         assign x_prev    = CORDIC_K_Q14;
         assign y_prev    = '0;
         assign z_prev    = pr_z_ff;
      end else begin : g_next
         assign tag_prev  = st_tag_ff[i-1];
         assign flip_prev = st_flip_ff[i-1];
         assign x_prev    = st_x_ff[i-1];
         assign y_prev    = st_y_ff[i-1];
         assign z_prev    = st_z_ff[i-1];
      end
      assign dx   = y_prev >>> i;
      assign dy   = x_prev >>> i;
      assign step = $signed({2'b00, ATAN_TURNS_Q32[i]});
      always_ff @(posedge clock) begin
         if (reset) st_tag_ff[i].valid <= 1'b0;
         else if (en) st_tag_ff[i].valid <= tag_prev.valid;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            st_tag_ff[i].ang16  <= tag_prev.ang16;
            st_tag_ff[i].radius <= tag_prev.radius;
            st_tag_ff[i].last   <= tag_prev.last;
            st_flip_ff[i]       <= flip_prev;
            if (!z_prev[Z_W-1]) begin
               st_x_ff[i] <= x_prev - dx;
               st_y_ff[i] <= y_prev + dy;
               st_z_ff[i] <= z_prev - step;
            end else begin
               st_x_ff[i] <= x_prev + dx;
               st_y_ff[i] <= y_prev - dy;
               st_z_ff[i] <= z_prev + step;
            end
         end
      end
   end

   tag_type                 fl_tag_ff;
   logic signed [VEC_W-1:0] fl_x_ff, fl_y_ff;

   always_ff @(posedge clock) begin
      if (reset) fl_tag_ff.valid <= 1'b0;
      else if (en) fl_tag_ff.valid <= st_tag_ff[N-1].valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fl_tag_ff.ang16  <= st_tag_ff[N-1].ang16;
         fl_tag_ff.radius <= st_tag_ff[N-1].radius;
         fl_tag_ff.last   <= st_tag_ff[N-1].last;
         fl_x_ff <= st_flip_ff[N-1] ? -st_x_ff[N-1] : st_x_ff[N-1];
         fl_y_ff <= st_flip_ff[N-1] ? -st_y_ff[N-1] : st_y_ff[N-1];
      end
   end

   assign out_tag = fl_tag_ff;
   assign cos_q14 = fl_x_ff;
   assign sin_q14 = fl_y_ff;
endmodule

[hw/rtl/opc_position.sv]
// Screen position: radius products added to center x and subtracted from
// center y, truncation toward zero, saturate to 13 bits. Holds the result register. Uses opc_pkg.
module opc_position (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic [opc_pkg::CEN_W-1:0]        center_x,
   input  logic [opc_pkg::CEN_W-1:0]        center_y,
   input  opc_pkg::tag_type                 in_tag,
   input  logic signed [opc_pkg::VEC_W-1:0] cos_q14,
   input  logic signed [opc_pkg::VEC_W-1:0] sin_q14,
   output logic                             out_valid,
   output logic signed [opc_pkg::POS_W-1:0] pos_x,
   output logic signed [opc_pkg::POS_W-1:0] pos_y,
   output logic [opc_pkg::ANG_W-1:0]        angle_turns,
   output logic                             last_out
);
   import opc_pkg::*;

   localparam int SHIFTED_W = SUM_W - Q14;
   localparam logic signed [SHIFTED_W-1:0] POS_MAX = SHIFTED_W'(4095);
   localparam logic signed [SHIFTED_W-1:0] POS_MIN = -SHIFTED_W'(4096);

   function automatic logic signed [POS_W-1:0] to_pixel(logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-1:0]     adj;
      logic signed [SHIFTED_W-1:0] q;
      adj = s[SUM_W-1] ? SUM_W'(s + SUM_W'((1 << Q14) - 1)) : s;
      q   = SHIFTED_W'(adj >>> Q14);
      if (q > POS_MAX) return POS_W'(POS_MAX);
      if (q < POS_MIN) return POS_W'(POS_MIN);
      return q[POS_W-1:0];
   endfunction

   tag_type                  mu_tag_ff;
   logic signed [PROD_W-1:0] mu_px_ff, mu_py_ff;
   logic signed [RAD_W:0]    rad_s;

   assign rad_s = $signed({1'b0, in_tag.radius});

   always_ff @(posedge clock) begin
      if (reset) mu_tag_ff.valid <= 1'b0;
      else if (en) mu_tag_ff.valid <= in_tag.valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mu_tag_ff.ang16  <= in_tag.ang16;
         mu_tag_ff.radius <= in_tag.radius;
         mu_tag_ff.last   <= in_tag.last;
         mu_px_ff <= PROD_W'(cos_q14 * rad_s);
         mu_py_ff <= PROD_W'(sin_q14 * rad_s);
      end
   end

   logic signed [SUM_W-1:0] sum_x, sum_y;
   assign sum_x = $signed({1'b0, center_x, Q14'(0)}) + SUM_W'(mu_px_ff);
   assign sum_y = $signed({1'b0, center_y, Q14'(0)}) - SUM_W'(mu_py_ff);

   logic                    out_v_ff;
   logic signed [POS_W-1:0] pos_x_ff, pos_y_ff;
   logic [ANG_W-1:0]        ang_ff;
   logic                    last_ff;

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (en) out_v_ff <= mu_tag_ff.valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_x_ff <= to_pixel(sum_x);
         pos_y_ff <= to_pixel(sum_y);
         ang_ff   <= mu_tag_ff.ang16;
         last_ff  <= mu_tag_ff.last;
      end
   end

   assign out_valid   = out_v_ff;
   assign pos_x       = pos_x_ff;
   assign pos_y       = pos_y_ff;
   assign angle_turns = ang_ff;
   assign last_out    = last_ff;
endmodule

[hw/rtl/opc_checker.sv]
// Port-level checks for the orbit position calculator, bound to the top.
// Depends on opc_pkg and orbit_position_calculator.
module opc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [opc_pkg::POS_W-1:0] pos_x,
   input logic signed [opc_pkg::POS_W-1:0] pos_y,
   input logic [opc_pkg::ANG_W-1:0]        angle_turns,
   input logic                             last_out
);
   import opc_pkg::*;

   // Reset empties the pipeline, so no result is offered right after it.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // The input side only waits when a result is held back.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled without output backpressure");

   // A result waiting at the output blocks new transactions.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !(req_valid && req_ready))
      else $error("input accepted while the pipeline is frozen");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(pos_x) && $stable(pos_y)
                                     && $stable(angle_turns) && $stable(last_out)))
      else $error("stalled result changed");
endmodule

bind orbit_position_calculator opc_checker u_opc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .pos_x       (rsp_ch.pos_x),
   .pos_y       (rsp_ch.pos_y),
   .angle_turns (rsp_ch.angle_turns),
   .last_out    (rsp_ch.last_out)
);

[verif/tb_orbit_position_calculator.sv]
// Self-checking testbench for the orbit position calculator: drives bodies with
// random idling, predicts each screen position and compares it field by field.
// Depends on opc_pkg, opc_if and the orbit_position_calculator RTL.
module tb_orbit_position_calculator;
   import opc_pkg::*;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [ANG_W-1:0]        angle_turns;
      logic                    last_out;
   } position_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   opc_req_if req_ch ();
   opc_rsp_if rsp_ch ();

   orbit_position_calculator dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   localparam int LATENCY = 79;

   logic [11:0] model_center_x = 12'd0;
   logic [11:0] model_center_y = 12'd0;
   logic [15:0] model_gain = 16'd256;
   position_type expected_positions[$];
   int error_count = 0;
   bit stalls_enabled = 1'b1;

   always #6 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.day = '0;
      req_ch.base_angle_turns = '0;
      req_ch.period_days = '0;
      req_ch.orbit_radius = '0;
      req_ch.last_in = 1'b0;
      rsp_ch.ready = 1'b0;
   end

   function automatic logic signed [31:0] floor_shift(logic signed [31:0] v, int s);
      return v >>> s;
   endfunction

   function automatic logic signed [POS_W-1:0] clamp_position(longint v);
      if (v > 4095) return 13'sd4095;
      if (v < -4096) return -13'sd4096;
      return v[POS_W-1:0];
   endfunction

   function automatic position_type predict_position(logic signed [31:0] day,
         logic [15:0] base, logic [15:0] period, logic [9:0] radius, logic last);
      position_type p;
      longint unsigned den, mag, rem, inc, angle, a32;
      longint z, px, py;
      logic signed [31:0] vx, vy, dx, dy;
      bit flip;
      inc = 0;
      flip = 1'b0;
      vx = 9949;
      vy = 0;
      if (period != 0) begin
         den = 256 * longint'(period);
         if (day < 0) mag = longint'(-longint'(day)) * model_gain;
         else mag = longint'(day) * model_gain;
         rem = mag % den;
         if (day < 0 && rem != 0) rem = den - rem;
         inc = (rem << 16) / den;
      end
      angle = (base + inc) & 64'hFFFF;
      a32 = angle << 16;
      if (a32 >= 64'h40000000 && a32 < 64'hC0000000) begin
         z = longint'(a32) - 64'sh80000000;
         flip = 1'b1;
      end else if (a32 >= 64'hC0000000) begin
         z = longint'(a32) - 64'sh100000000;
      end else begin
         z = longint'(a32);
      end
      for (int i = 0; i < CORDIC_USED; i++) begin
         dx = floor_shift(vy, i);
         dy = floor_shift(vx, i);
         if (z >= 0) begin
            vx = vx - dx;
            vy = vy + dy;
            z = z - longint'(ATAN_TURNS_Q32[i]);
         end else begin
            vx = vx + dx;
            vy = vy - dy;
            z = z + longint'(ATAN_TURNS_Q32[i]);
         end
      end
      if (flip) begin
         vx = -vx;
         vy = -vy;
      end
      // SystemVerilog division truncates toward zero, as the position needs.
      px = (longint'(model_center_x) * 16384 + longint'(vx) * longint'(radius)) / 16384;
      py = (longint'(model_center_y) * 16384 - longint'(vy) * longint'(radius)) / 16384;
      p.pos_x = clamp_position(px);
      p.pos_y = clamp_position(py);
      p.angle_turns = angle[15:0];
      p.last_out = last;
      return p;
   endfunction

   task automatic send_body(logic signed [31:0] day, logic [15:0] base,
         logic [15:0] period, logic [9:0] radius, logic last);
      int gap;
      gap = stalls_enabled ? $urandom_range(0, 8) : 0;
      repeat (gap) @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.day = day;
      req_ch.base_angle_turns = base;
      req_ch.period_days = period;
      req_ch.orbit_radius = radius;
      req_ch.last_in = last;
      do @(posedge clock); while (!req_ch.ready);
      expected_positions.push_back(predict_position(day, base, period, radius, last));
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic write_register(logic [1:0] index, logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = CSR_ADDR_W'({index, 2'b00});
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_CENTER_X: model_center_x = value[11:0];
         REG_CENTER_Y: model_center_y = value[11:0];
         REG_SPEED_GAIN: model_gain = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_positions.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   task automatic set_registers(logic [11:0] cx, logic [11:0] cy, logic [15:0] gain);
      wait_drained();
      write_register(REG_CENTER_X, 32'(cx));
      write_register(REG_CENTER_Y, 32'(cy));
      write_register(REG_SPEED_GAIN, 32'(gain));
   endtask

   task automatic random_body(bit well_formed);
      logic signed [31:0] day;
      logic [15:0] period;
      day = $urandom();
      if (!$urandom_range(0, 3)) day = $signed(32'($urandom_range(0, 2000))) - 1000;
      period = 16'($urandom());
      if (well_formed && $urandom_range(0, 1)) period = 16'($urandom_range(1, 400));
      if (!$urandom_range(0, 20)) period = 16'd0;
      send_body(day, 16'($urandom()), period, 10'($urandom()), 1'($urandom_range(0, 1)));
   endtask

   task automatic test_directed();
      send_body(32'sd0, 16'h0000, 16'd1, 10'd0, 1'b0);
      send_body(32'sh7FFFFFFF, 16'hFFFF, 16'hFFFF, 10'd1023, 1'b1);
      send_body(32'sh80000000, 16'h0000, 16'hFFFF, 10'd1023, 1'b0);
      send_body(-32'sd1, 16'h4000, 16'd7, 10'd1023, 1'b1);
      send_body(32'sd100, 16'h8000, 16'd0, 10'd1023, 1'b0);
      for (int q = 0; q < 8; q++)
         send_body(32'sd0, 16'(q * 16'h2000), 16'd365, 10'd1023, q[0]);
      send_body(32'sd3, 16'h3FFF, 16'd12, 10'd512, 1'b0);
      send_body(32'sd5, 16'hBFFF, 16'd1, 10'd1, 1'b1);
   endtask

   task automatic test_register_extremes();
      set_registers(12'd4095, 12'd4095, 16'hFFFF);
      for (int i = 0; i < 12; i++) random_body(1'b1);
      set_registers(12'd0, 12'd0, 16'd0);
      for (int i = 0; i < 12; i++) random_body(1'b1);
      set_registers(12'd2048, 12'd100, 16'd256);
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 6; phase++) begin
         set_registers(12'($urandom()), 12'($urandom()), 16'($urandom()));
         stalls_enabled = (phase != 2);
         for (int i = 0; i < 270; i++) random_body($urandom_range(0, 9) != 0);
         // Let the pipeline empty completely before feeding more.
         if (phase == 3) wait_drained();
      end
      stalls_enabled = 1'b1;
   endtask

   // The sink draws a stall per transaction; none while stalls are disabled.
   initial begin
      int stall;
      @(negedge clock);
      forever begin
         stall = stalls_enabled ? $urandom_range(0, 8) : 0;
         rsp_ch.ready = 1'b0;
         repeat (stall) @(negedge clock);
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_positions.size() == 0) begin
            $error("unexpected transaction: pos_x %0d pos_y %0d", rsp_ch.pos_x, rsp_ch.pos_y);
            error_count++;
         end else begin
            position_type e;
            e = expected_positions.pop_front();
            if (rsp_ch.pos_x !== e.pos_x) begin
               $error("pos_x expected %0d actual %0d", e.pos_x, rsp_ch.pos_x);
               error_count++;
            end
            if (rsp_ch.pos_y !== e.pos_y) begin
               $error("pos_y expected %0d actual %0d", e.pos_y, rsp_ch.pos_y);
               error_count++;
            end
            if (rsp_ch.angle_turns !== e.angle_turns) begin
               $error("angle_turns expected %0d actual %0d", e.angle_turns,
                      rsp_ch.angle_turns);
               error_count++;
            end
            if (rsp_ch.last_out !== e.last_out) begin
               $error("last_out expected %0d actual %0d", e.last_out, rsp_ch.last_out);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_register_extremes();
      test_random();
      wait_drained();
      if (error_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #3000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/opc_pkg.sv
hw/rtl/opc_if.sv
hw/rtl/opc_phase.sv
hw/rtl/opc_cordic.sv
hw/rtl/opc_position.sv
hw/rtl/orbit_position_calculator.sv
hw/rtl/opc_checker.sv
verif/tb_orbit_position_calculator.sv
